// File: design/mouse_packet_position_tracker_defines.svh
// Assertion macros shared by the checker.
`ifndef MOUSE_PACKET_POSITION_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_POSITION_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MPT_ASSERT_IMP(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MPT_ASSERT_NXT(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, live through reset
`define MPT_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mpt_pkg.sv
package mpt_pkg;

    localparam logic [12:0] CURSOR_SIZE = 13'd5;
    localparam logic [11:0] MAX_POS     = 12'd4095;

    localparam int unsigned SYNC_BIT = 3;
    localparam logic [7:0]  OVF_MASK = 8'hC0;
    localparam int unsigned LEFT_BIT = 0;

    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd200;
    localparam logic [11:0] RST_BUTTON_LEFT   = 12'd32;
    localparam logic [11:0] RST_BUTTON_TOP    = 12'd48;
    localparam logic [11:0] RST_BUTTON_WIDTH  = 12'd80;
    localparam logic [11:0] RST_BUTTON_HEIGHT = 12'd16;
    localparam logic [11:0] RST_CURSOR_X      = 12'd160;
    localparam logic [11:0] RST_CURSOR_Y      = 12'd100;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OUT_W  = 32;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_GRAPHICS_MODE = 3'd2,
        REG_BUTTON_LEFT   = 3'd3,
        REG_BUTTON_TOP    = 3'd4,
        REG_BUTTON_WIDTH  = 3'd5,
        REG_BUTTON_HEIGHT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic        graphics_mode;
        logic [11:0] button_left;
        logic [11:0] button_top;
        logic [11:0] button_width;
        logic [11:0] button_height;
    } t_cfg;

    typedef struct packed {
        logic [2:0] btn;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_pkt;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  btn;
    } t_pos;

endpackage

// File: design/mpt_cfg.sv
module mpt_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpt_pkg::ADDR_W-1:0]   paddr,
    input  logic [mpt_pkg::DATA_W-1:0]   pwdata,
    output logic [mpt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output mpt_pkg::t_cfg                o_cfg
);
    import mpt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.graphics_mode <= 1'b0;
            r_cfg.button_left   <= RST_BUTTON_LEFT;
            r_cfg.button_top    <= RST_BUTTON_TOP;
            r_cfg.button_width  <= RST_BUTTON_WIDTH;
            r_cfg.button_height <= RST_BUTTON_HEIGHT;
        end else if (wr_en) begin
            case (idx)
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[12:0];
                REG_GRAPHICS_MODE: r_cfg.graphics_mode <= pwdata[0];
                REG_BUTTON_LEFT:   r_cfg.button_left   <= pwdata[11:0];
                REG_BUTTON_TOP:    r_cfg.button_top    <= pwdata[11:0];
                REG_BUTTON_WIDTH:  r_cfg.button_width  <= pwdata[11:0];
                REG_BUTTON_HEIGHT: r_cfg.button_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_SCREEN_WIDTH:  prdata = DATA_W'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(r_cfg.screen_height);
            REG_GRAPHICS_MODE: prdata = DATA_W'(r_cfg.graphics_mode);
            REG_BUTTON_LEFT:   prdata = DATA_W'(r_cfg.button_left);
            REG_BUTTON_TOP:    prdata = DATA_W'(r_cfg.button_top);
            REG_BUTTON_WIDTH:  prdata = DATA_W'(r_cfg.button_width);
            REG_BUTTON_HEIGHT: prdata = DATA_W'(r_cfg.button_height);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: design/mpt_framer.sv
module mpt_framer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    output logic          o_pkt_valid,
    output mpt_pkg::t_pkt o_pkt,
    input  logic          i_pkt_ready
);
    import mpt_pkg::*;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_status, n_status;
    logic [7:0] r_dx, n_dx;
    logic       r_pkt_vld, n_pkt_vld;
    t_pkt       r_pkt, n_pkt;
    logic       accept;
    logic       load;

    assign o_ready     = !r_pkt_vld || i_pkt_ready;
    assign accept      = i_valid && o_ready;
    assign o_pkt_valid = r_pkt_vld;
    assign o_pkt       = r_pkt;

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_dx     = r_dx;
        load     = 1'b0;
        case (r_phase)
            PH_DX: begin
                n_dx    = i_byte;
                n_phase = PH_DY;
            end
            PH_DY: begin
                n_phase = PH_STATUS;
                load    = (r_status & OVF_MASK) == 8'h00;
            end
            default: begin
                if (i_byte[SYNC_BIT]) begin
                    n_status = i_byte;
                    n_phase  = PH_DX;
                end else begin
                    n_phase  = PH_STATUS;
                end
            end
        endcase
        n_pkt.btn = r_status[2:0];
        n_pkt.dx  = r_dx;
        n_pkt.dy  = i_byte;
        if (accept && load) begin
            n_pkt_vld = 1'b1;
        end else if (i_pkt_ready) begin
            n_pkt_vld = 1'b0;
        end else begin
            n_pkt_vld = r_pkt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STATUS;
            r_status  <= '0;
            r_dx      <= '0;
            r_pkt_vld <= 1'b0;
        end else begin
            r_pkt_vld <= n_pkt_vld;
            if (accept) begin
                r_phase  <= n_phase;
                r_status <= n_status;
                r_dx     <= n_dx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && load) begin
            r_pkt <= n_pkt;
        end
    end

endmodule

// File: design/mpt_position.sv
module mpt_position (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mpt_pkg::t_cfg i_cfg,
    input  logic          i_pkt_valid,
    input  mpt_pkg::t_pkt i_pkt,
    output logic          o_pkt_ready,
    output logic          o_pos_valid,
    output mpt_pkg::t_pos o_pos,
    input  logic          i_pos_ready
);
    import mpt_pkg::*;

    logic [11:0] r_cur_x, r_cur_y;
    logic [2:0]  r_btn;
    logic        r_vld;
    logic [13:0] dx_s, dy_s;
    logic [13:0] nx, ny;
    logic [11:0] lim_x, lim_y;
    logic [11:0] n_x, n_y;
    logic        take;

    function automatic logic [11:0] clamp_limit(input logic [12:0] size);
        logic [12:0] diff;
        diff = size - CURSOR_SIZE;
        if (size < CURSOR_SIZE) begin
            return '0;
        end else if (diff > {1'b0, MAX_POS}) begin
            return MAX_POS;
        end else begin
            return diff[11:0];
        end
    endfunction

    function automatic logic [11:0] clamp_pos(input logic [13:0] pos,
                                              input logic [11:0] lim);
        if (pos[13]) begin
            return '0;
        end else if (pos[12:0] >= {1'b0, lim}) begin
            return lim;
        end else begin
            return pos[11:0];
        end
    endfunction

    assign o_pkt_ready = !r_vld || i_pos_ready;
    assign take        = i_pkt_valid && o_pkt_ready;

    assign dx_s  = {{4{i_pkt.dx[7]}}, i_pkt.dx, 2'b00};
    assign dy_s  = {{4{i_pkt.dy[7]}}, i_pkt.dy, 2'b00};
    assign nx    = {2'b00, r_cur_x} + dx_s;
    assign ny    = {2'b00, r_cur_y} - dy_s;
    assign lim_x = clamp_limit(i_cfg.screen_width);
    assign lim_y = clamp_limit(i_cfg.screen_height);
    assign n_x   = clamp_pos(nx, lim_x);
    assign n_y   = clamp_pos(ny, lim_y);

    assign o_pos_valid = r_vld;
    assign o_pos.x     = r_cur_x;
    assign o_pos.y     = r_cur_y;
    assign o_pos.btn   = r_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= RST_CURSOR_X;
            r_cur_y <= RST_CURSOR_Y;
            r_vld   <= 1'b0;
        end else begin
            if (take) begin
                r_cur_x <= n_x;
                r_cur_y <= n_y;
                r_vld   <= 1'b1;
            end else if (i_pos_ready) begin
                r_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_btn <= i_pkt.btn;
        end
    end

endmodule

// File: design/mpt_output.sv
module mpt_output (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mpt_pkg::t_cfg              i_cfg,
    input  logic                       i_pos_valid,
    input  mpt_pkg::t_pos              i_pos,
    output logic                       o_pos_ready,
    output logic                       o_valid,
    output logic [mpt_pkg::OUT_W-1:0]  o_data,
    input  logic                       i_ready
);
    import mpt_pkg::*;

    logic             r_vld;
    logic [OUT_W-1:0] r_data;
    logic [OUT_W-1:0] n_data;
    logic [12:0]      right, bottom;
    logic             in_x, in_y, hit;
    logic             take;

    assign o_pos_ready = !r_vld || i_ready;
    assign take        = i_pos_valid && o_pos_ready;

    assign right  = {1'b0, i_cfg.button_left} + {1'b0, i_cfg.button_width};
    assign bottom = {1'b0, i_cfg.button_top} + {1'b0, i_cfg.button_height};
    assign in_x   = (i_pos.x >= i_cfg.button_left) && ({1'b0, i_pos.x} < right);
    assign in_y   = (i_pos.y >= i_cfg.button_top) && ({1'b0, i_pos.y} < bottom);
    assign hit    = i_pos.btn[LEFT_BIT] && i_cfg.graphics_mode && in_x && in_y;

    assign n_data = OUT_W'({i_cfg.graphics_mode, hit, i_pos.btn, i_pos.y, i_pos.x});

    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

endmodule

// File: design/mouse_packet_position_tracker.sv
// Channel   Dir  Width  Contents
// s stream  in   8      tdata: rx_byte
// m stream  out  32     tdata: pos_x, pos_y, buttons, hit_pressed, display_notify
// APB       in   5/32   seven control registers at byte addresses 0 to 24
//
// One byte per cycle is taken while the pipeline is not stalled; a result
// passes from the packet's last byte through framer, position and output registers.
// A stalled result holds the pipeline only as far as the registers fill.
// Synchronous active-low reset: framing restarts, cursor goes to 160,100.
module mouse_packet_position_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] rx_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [11:0] pos_x, [23:12] pos_y, [26:24] buttons, [27] hit_pressed,
    // [28] display_notify, [31:29] zero
    output logic [mpt_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [mpt_pkg::DATA_W-1:0]  pwdata,
    output logic [mpt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mpt_pkg::*;

    t_cfg cfg;
    t_pkt pkt;
    t_pos pos;
    logic pkt_vld, pkt_rdy;
    logic pos_vld, pos_rdy;

    mpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpt_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .o_ready     (o_s_tready),
        .o_pkt_valid (pkt_vld),
        .o_pkt       (pkt),
        .i_pkt_ready (pkt_rdy)
    );

    mpt_position u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pkt_valid (pkt_vld),
        .i_pkt       (pkt),
        .o_pkt_ready (pkt_rdy),
        .o_pos_valid (pos_vld),
        .o_pos       (pos),
        .i_pos_ready (pos_rdy)
    );

    mpt_output u_output (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pos_valid (pos_vld),
        .i_pos       (pos),
        .o_pos_ready (pos_rdy),
        .o_valid     (o_m_tvalid),
        .o_data      (o_m_tdata),
        .i_ready     (i_m_tready)
    );

endmodule

// File: design/mpt_checker.sv
`include "mouse_packet_position_tracker_defines.svh"

module mpt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [mpt_pkg::OUT_W-1:0] o_m_tdata
);
    import mpt_pkg::*;

    // hold a stalled beat
    `MPT_ASSERT_NXT(a_out_hold, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")

    // drop any result across reset
    `MPT_ASSERT_NXT_ALWAYS(a_rst_empty, !i_rst_n, !o_m_tvalid, "result valid right after reset")

    // hit needs left button and graphics mode
    `MPT_ASSERT_IMP(a_hit_cond, i_rst_n, o_m_tvalid && o_m_tdata[27], o_m_tdata[24] && o_m_tdata[28], "hit flagged without left button in graphics mode")

endmodule

bind mouse_packet_position_tracker mpt_checker u_chk (.*);
